// ===== rtl/bounded_integer_set_table_assert.svh =====
// assertion macros for the bounded integer set table
// used by the top level; expects clk_i and rst_ni in scope
`ifndef BOUNDED_INTEGER_SET_TABLE_ASSERT_SVH
`define BOUNDED_INTEGER_SET_TABLE_ASSERT_SVH

// same-cycle implication
`define BIST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bist assertion failed");

// next-cycle implication
`define BIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bist assertion failed");

`endif

// ===== rtl/bist_pkg.sv =====
// shared types and constants for the bounded integer set table
// no dependencies
package bist_pkg;

  localparam int MaxElementsDef = 64;
  localparam int ValueW         = 32;
  localparam int CountW         = 7;
  localparam int CapW           = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    ReqInsert = 2'd0,
    ReqRemove = 2'd1,
    ReqLookup = 2'd2
  } req_e;

  typedef struct packed {
    logic              valid;
    logic              success;
    logic [CountW-1:0] count;
  } resp_t;

endpackage

// ===== rtl/bist_mem.sv =====
// entry store: one write port, one read port with registered read data
// depends on nothing but its parameters
module bist_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bist_seq.sv =====
// sequencer: scans the store with one shared comparator, shifts on removal
// depends on bist_pkg
module bist_seq
  import bist_pkg::*;
#(
  parameter int MAX_ELEMENTS = MaxElementsDef,
  parameter int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [ValueW-1:0] req_value_i,
  input  logic [CapW-1:0]   cap_i,
  input  logic              out_free_i,
  output resp_t             resp_o,
  output logic              re_o,
  output logic [AW-1:0]     raddr_o,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [ValueW-1:0] wdata_o,
  input  logic [ValueW-1:0] rdata_i
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int XW = (CW > CapW) ? CW : CapW;
  localparam logic [XW-1:0] MaxX = XW'(MAX_ELEMENTS);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StResp
  } state_e;

  state_e            state_q, state_d;
  req_e              op_q, op_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic              ok_q, ok_d;
  logic [CW-1:0]     count_q, count_d;

  logic [XW-1:0] cap_x, cap_eff, count_x;
  logic          room;
  logic          hit;
  logic          more;
  logic [CW-1:0] pidx_dec;

  assign cap_x    = XW'(cap_i);
  assign cap_eff  = (cap_x > MaxX) ? MaxX : cap_x;
  assign count_x  = XW'(count_q);
  assign room     = count_x < cap_eff;
  assign hit      = pend_q && (rdata_i == val_q);
  assign more     = idx_q < count_q;
  assign pidx_dec = pidx_q - CW'(1);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    val_d   = val_q;
    idx_d   = idx_q;
    pidx_d  = pidx_q;
    pend_d  = pend_q;
    ok_d    = ok_q;
    count_d = count_q;
    re_o    = 1'b0;
    raddr_o = idx_q[AW-1:0];
    we_o    = 1'b0;
    waddr_o = pidx_dec[AW-1:0];
    wdata_o = rdata_i;
    resp_o  = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          val_d  = req_value_i;
          idx_d  = '0;
          pend_d = 1'b0;
          ok_d   = 1'b0;
          unique case (req_type_i)
            ReqInsert: begin
              op_d    = ReqInsert;
              state_d = StScan;
            end
            ReqRemove: begin
              op_d    = ReqRemove;
              state_d = StScan;
            end
            ReqLookup: begin
              op_d    = ReqLookup;
              state_d = StScan;
            end
            default: begin
              // unused code: no change, fails
              op_d    = ReqLookup;
              state_d = StResp;
            end
          endcase
        end
      end
      StScan: begin
        re_o   = more;
        pend_d = more;
        pidx_d = idx_q;
        if (more) begin
          idx_d = idx_q + CW'(1);
        end
        if (hit) begin
          pend_d = 1'b0;
          unique case (op_q)
            ReqRemove: begin
              idx_d   = pidx_q + CW'(1);
              ok_d    = 1'b1;
              state_d = StShift;
            end
            ReqLookup: begin
              ok_d    = 1'b1;
              state_d = StResp;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = StResp;
            end
          endcase
        end else if (!pend_q && !more) begin
          ok_d    = (op_q == ReqInsert) && room;
          state_d = StResp;
        end
      end
      StShift: begin
        // read entry r, write it to r-1 in the next cycle, once the read data is registered
        re_o   = more;
        pend_d = more;
        pidx_d = idx_q;
        if (more) begin
          idx_d = idx_q + CW'(1);
        end
        we_o = pend_q;
        if (!pend_q && !more) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (out_free_i) begin
          resp_o.valid   = 1'b1;
          resp_o.success = ok_q;
          if (ok_q && op_q == ReqInsert) begin
            we_o    = 1'b1;
            waddr_o = count_q[AW-1:0];
            wdata_o = val_q;
            count_d = count_q + CW'(1);
          end else if (ok_q && op_q == ReqRemove) begin
            count_d = count_q - CW'(1);
          end
          resp_o.count = count_x[CountW-1:0];
          if (ok_q && op_q == ReqInsert) begin
            resp_o.count = count_x[CountW-1:0] + CountW'(1);
          end else if (ok_q && op_q == ReqRemove) begin
            resp_o.count = count_x[CountW-1:0] - CountW'(1);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= ReqLookup;
      val_q   <= '0;
      idx_q   <= '0;
      pidx_q  <= '0;
      pend_q  <= 1'b0;
      ok_q    <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      val_q   <= val_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pend_q  <= pend_d;
      ok_q    <= ok_d;
      count_q <= count_d;
    end
  end

  assign req_ready_o = (state_q == StIdle);

endmodule

// ===== rtl/bounded_integer_set_table.sv =====
// flow: each accepted word scans the stored entries until a match or the end, a remove then
// shifts the later entries down, and the result word is registered; the store gives one read per cycle
// throughput: one word at a time; the next word is taken once the result is registered
// reset: control and count cleared, capacity 64, entry store undefined (never read unwritten)
// top level: capacity register, result register, sequencer and entry store
// depends on bist_pkg, bist_seq, bist_mem and bounded_integer_set_table_assert.svh
`include "bounded_integer_set_table_assert.svh"

module bounded_integer_set_table
  import bist_pkg::*;
#(
  parameter int MAX_ELEMENTS = MaxElementsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic signed [ValueW-1:0] s_axis_tdata,   // value[31:0]
  input  logic [1:0]               s_axis_tuser,   // req_type[1:0]
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // count[6:0], zero pad [7]
  output logic                     m_axis_tuser,   // success[0]
  input  logic                     cfg_we_i,
  input  logic [CapW-1:0]          cfg_wdata_i
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [CapW-1:0]   cap_q;
  logic              m_valid_q;
  logic              m_success_q;
  logic [CountW-1:0] m_count_q;
  logic              out_free;
  resp_t             resp;

  logic              re, we;
  logic [AW-1:0]     raddr, waddr;
  logic [ValueW-1:0] wdata, rdata;

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (resp.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.valid) begin
      m_success_q <= resp.success;
      m_count_q   <= resp.count;
    end
  end

  bist_seq #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .AW          (AW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_type_i (s_axis_tuser),
    .req_value_i(s_axis_tdata),
    .cap_i      (cap_q),
    .out_free_i (out_free),
    .resp_o     (resp),
    .re_o       (re),
    .raddr_o    (raddr),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .rdata_i    (rdata)
  );

  bist_mem #(
    .DEPTH(MAX_ELEMENTS),
    .AW   (AW),
    .DW   (ValueW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (re),
    .raddr_i(raddr),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_success_q;
  assign m_axis_tdata  = {1'b0, m_count_q};

  `BIST_ASSERT_NOW(a_resp_into_free, resp.valid, out_free)
  `BIST_ASSERT_NOW(a_no_resp_when_idle, s_axis_tready, !resp.valid)
  `BIST_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
